@@ rtl/core/nearest_palette_colour_match_assert.svh @@
// ----------------------------------------------------------------------------
// Nearest palette colour match - assertion macros
// Concurrent checks clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef NEAREST_PALETTE_COLOUR_MATCH_ASSERT_SVH
`define NEAREST_PALETTE_COLOUR_MATCH_ASSERT_SVH

// Same-cycle implication.
`define NPCM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define NPCM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/npcm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npcm_pkg
// Shared types, widths and the reset palette of the colour match block.
// ----------------------------------------------------------------------------
package npcm_pkg;

  localparam int PAL_DEPTH = 128;
  localparam int IDX_W     = $clog2(PAL_DEPTH);
  localparam int CNT_W     = $clog2(PAL_DEPTH + 1);
  localparam int COL_W     = 24;
  localparam int DIST_W    = 18;
  localparam int SIZE_W    = 8;

  localparam logic KIND_QUERY = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  // Palette port request: one write and one read per cycle.
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [COL_W-1:0] wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } pal_req_t;

  // Tag that travels beside one palette entry through the distance pipe.
  typedef struct packed {
    logic             vld;
    logic             last;
    logic [IDX_W-1:0] idx;
  } scan_tag_t;

  // Reset palette, R<<16 | G<<8 | B; the final entry resets to black.
  localparam logic [COL_W-1:0] PAL_RESET [PAL_DEPTH] = '{
    24'h000000, 24'hf5f5f5, 24'h2a77a1, 24'h840410, 24'h263739, 24'h86446e, 24'hd78e10,
    24'h4c75b7, 24'hbdbec6, 24'h5e7072, 24'h46597a, 24'h656a79, 24'h5d7e8d, 24'h58595a,
    24'hd6dad6, 24'h9ca1a3, 24'h335f3f, 24'h730e1a, 24'h7b0a2a, 24'h9f9d94, 24'h3b4e78,
    24'h732e3e, 24'h691e3b, 24'h96918c, 24'h515459, 24'h3f3e45, 24'ha5a9a7, 24'h635c5a,
    24'h3d4a68, 24'h979592, 24'h421f21, 24'h5f272b, 24'h8494ab, 24'h767b7c, 24'h646464,
    24'h5a5752, 24'h252527, 24'h2d3a35, 24'h93a396, 24'h6d7a88, 24'h221918, 24'h6f675f,
    24'h7c1c2a, 24'h5f0a15, 24'h193826, 24'h5d1b20, 24'h9d9872, 24'h7a7560, 24'h989586,
    24'hadb0b0, 24'h848988, 24'h304f45, 24'h4d6268, 24'h162248, 24'h272f4b, 24'h7d6256,
    24'h9ea4ab, 24'h9c8d71, 24'h6d1822, 24'h4e6881, 24'h9c9c98, 24'h917347, 24'h661c26,
    24'h949d9f, 24'ha4a7a5, 24'h8e8c46, 24'h341a1e, 24'h6a7a8c, 24'haaad8e, 24'hab988f,
    24'h851f2e, 24'h6f8297, 24'h585853, 24'h9aa790, 24'h601a23, 24'h20202c, 24'ha4a096,
    24'haa9d84, 24'h78222b, 24'h0e316d, 24'h722a3f, 24'h7b715e, 24'h741d28, 24'h1e2e32,
    24'h4d322f, 24'h7c1b44, 24'h2e5b20, 24'h395a83, 24'h6d2837, 24'ha7a28f, 24'hafb1b1,
    24'h364155, 24'h6d6c6e, 24'h0f6a89, 24'h204b6b, 24'h2b3e57, 24'h9b9f9d, 24'h6c8495,
    24'h4d8495, 24'hae9b7f, 24'h406c8f, 24'h1f253b, 24'hab9276, 24'h134573, 24'h96816c,
    24'h64686a, 24'h105082, 24'ha19983, 24'h385694, 24'h525661, 24'h7f6956, 24'h8c929a,
    24'h596e87, 24'h473532, 24'h44624f, 24'h730a27, 24'h223457, 24'h640d1b, 24'ha3adc6,
    24'h695853, 24'h9b8b80, 24'h620b1c, 24'h5b5d5e, 24'h624428, 24'h731827, 24'h1b376d,
    24'hec6aae, 24'h000000
  };

endpackage

@@ rtl/core/npcm_palette.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npcm_palette
// Palette store: one write and one registered read per cycle. An entry not
// yet written since reset reads as its reset colour.
// ----------------------------------------------------------------------------
module npcm_palette (
  input  logic                      clk,
  input  logic                      rst,
  input  npcm_pkg::pal_req_t        req,
  output logic [npcm_pkg::COL_W-1:0] rcolour
);
  import npcm_pkg::*;

  logic [COL_W-1:0]     mem [PAL_DEPTH];
  logic [PAL_DEPTH-1:0] written;
  logic [COL_W-1:0]     rdata;
  logic                 rwritten;
  logic [IDX_W-1:0]     raddr;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (req.we) begin
      written[req.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rwritten <= written[req.raddr];
      raddr    <= req.raddr;
    end
  end

  assign rcolour = rwritten ? rdata : PAL_RESET[raddr];

endmodule

@@ rtl/core/npcm_dist.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npcm_dist
// Three-stage squared distance pipe: absolute differences, squares, sum.
// ----------------------------------------------------------------------------
module npcm_dist (
  input  logic                        clk,
  input  logic                        rst,
  input  npcm_pkg::scan_tag_t         tag_in,
  input  logic [npcm_pkg::COL_W-1:0]  entry,
  input  logic [npcm_pkg::COL_W-1:0]  query,
  output npcm_pkg::scan_tag_t         tag_out,
  output logic [npcm_pkg::DIST_W-1:0] sum_sq
);
  import npcm_pkg::*;

  scan_tag_t   tag1, tag2;
  logic [7:0]  diff [3];
  logic [7:0]  diff_next [3];
  logic [15:0] sq [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (entry[8*c +: 8] > query[8*c +: 8]) begin
        diff_next[c] = entry[8*c +: 8] - query[8*c +: 8];
      end else begin
        diff_next[c] = query[8*c +: 8] - entry[8*c +: 8];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      diff[c] <= diff_next[c];
      sq[c]   <= {8'b0, diff[c]} * {8'b0, diff[c]};
    end
    sum_sq <= {2'b0, sq[0]} + {2'b0, sq[1]} + {2'b0, sq[2]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1    <= '0;
      tag2    <= '0;
      tag_out <= '0;
    end else begin
      tag1    <= tag_in;
      tag2    <= tag1;
      tag_out <= tag2;
    end
  end

endmodule

@@ rtl/core/nearest_palette_colour_match.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_palette_colour_match
// Finds the palette entry nearest a query colour by squared Euclidean
// distance; write transactions replace one palette entry.
// ----------------------------------------------------------------------------
//  channel   dir  handshake           payload
//  s_*       in   s_tvalid/s_tready   tuser: kind; tdata: index, r, g, b
//  m_*       out  m_tvalid/m_tready   tdata: best_index, best_distance
//  cfg_*     in   cfg_wr_en           cfg_wr_data: palette_size
//
//  A write transaction lands in the palette as it is accepted. A query
//  walks N entries before its result is registered, N = palette_size clamped
//  to 1..128: the single palette read port fetches one entry per cycle.
//  Reset is synchronous; the palette reverts to its built-in colours at once
//  through per-entry written flags, so there is no clearing pass.
//  A stalled result holds in the output register while the next
//  transaction is accepted; a second finished query waits behind it.
// ----------------------------------------------------------------------------
module nearest_palette_colour_match (
  input  logic        clk,
  input  logic        rst,
  // palette_size
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  // tuser: [0] kind
  // tdata: [6:0] entry_index, [14:7] red, [22:15] green, [30:23] blue, [31] zero
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic        s_tuser,
  input  logic [31:0] s_tdata,
  // tdata: [6:0] best_index, [24:7] best_distance, [31:25] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata
);
  import npcm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t              state, state_next;
  logic [SIZE_W-1:0]   palette_size;
  logic [CNT_W-1:0]    count, count_next;
  logic [CNT_W-1:0]    issue_cnt;
  logic [COL_W-1:0]    query;
  logic [IDX_W-1:0]    best_idx;
  logic [DIST_W-1:0]   best_dist;
  logic [IDX_W-1:0]    out_idx;
  logic [DIST_W-1:0]   out_dist;
  logic                s_accept;
  logic                load_out;
  pal_req_t            pal_req;
  scan_tag_t           rd_tag, dist_tag;
  logic [COL_W-1:0]    entry;
  logic [DIST_W-1:0]   entry_dist;

  assign s_tready = (state == ST_IDLE);
  assign s_accept = s_tvalid && s_tready;
  assign load_out = (state == ST_DONE) && (!m_tvalid || m_tready);

  // Clamp the searched count to 1..PAL_DEPTH.
  always_comb begin
    if (palette_size == '0) begin
      count_next = CNT_W'(1);
    end else if (CNT_W'(palette_size) > CNT_W'(PAL_DEPTH)) begin
      count_next = CNT_W'(PAL_DEPTH);
    end else begin
      count_next = CNT_W'(palette_size);
    end
  end

  // Writes land directly in the palette; reads issue one entry a cycle.
  always_comb begin
    pal_req.we    = s_accept && (s_tuser == KIND_WRITE);
    pal_req.waddr = s_tdata[IDX_W-1:0];
    pal_req.wdata = {s_tdata[14:7], s_tdata[22:15], s_tdata[30:23]};
    pal_req.re    = (state == ST_SCAN) && (issue_cnt < count);
    pal_req.raddr = issue_cnt[IDX_W-1:0];
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_accept && (s_tuser == KIND_QUERY)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (dist_tag.vld && dist_tag.last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      palette_size <= SIZE_W'(127);
      rd_tag       <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        palette_size <= cfg_wr_data;
      end
      // Tag is registered to line up with the registered palette read.
      rd_tag.vld  <= pal_req.re;
      rd_tag.last <= (issue_cnt == count - CNT_W'(1));
      rd_tag.idx  <= issue_cnt[IDX_W-1:0];
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Hold query and running best; restart them on each accepted query.
  always_ff @(posedge clk) begin
    if (s_accept && (s_tuser == KIND_QUERY)) begin
      query     <= {s_tdata[14:7], s_tdata[22:15], s_tdata[30:23]};
      count     <= count_next;
      issue_cnt <= '0;
      best_idx  <= '0;
      best_dist <= '1;
    end else begin
      if (pal_req.re) begin
        issue_cnt <= issue_cnt + CNT_W'(1);
      end
      // Strictly nearer only, so a tie keeps the lower index.
      if (dist_tag.vld && (entry_dist < best_dist)) begin
        best_dist <= entry_dist;
        best_idx  <= dist_tag.idx;
      end
    end
    if (load_out) begin
      out_idx  <= best_idx;
      out_dist <= best_dist;
    end
  end

  assign m_tdata = {7'b0, out_dist, out_idx};

  npcm_palette u_palette (
    .clk     (clk),
    .rst     (rst),
    .req     (pal_req),
    .rcolour (entry)
  );

  npcm_dist u_dist (
    .clk     (clk),
    .rst     (rst),
    .tag_in  (rd_tag),
    .entry   (entry),
    .query   (query),
    .tag_out (dist_tag),
    .sum_sq  (entry_dist)
  );

  `include "nearest_palette_colour_match_assert.svh"

  // No palette write while a scan is reading it.
  `NPCM_ASSERT_IMP(a_no_write_in_scan, pal_req.we, state == ST_IDLE, "palette write outside idle")
  // Reads never go past the clamped count.
  `NPCM_ASSERT_IMP(a_read_in_range, pal_req.re, issue_cnt < count, "palette read beyond count")
  // The distance pipe is drained once the result is ready.
  `NPCM_ASSERT_IMP(a_drained_done, state == ST_DONE, !dist_tag.vld && !rd_tag.vld, "pipe not empty")
  // A loaded result never exceeds the largest possible distance.
  `NPCM_ASSERT_NXT(a_dist_bound, load_out, out_dist <= DIST_W'(195075), "distance out of range")

endmodule

@@ verif/nearest_palette_colour_match_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_palette_colour_match_test
// Self-checking bench for the palette colour matcher. A scoreboard keeps its
// own palette and palette size, works out the nearest entry of every query
// transaction it sees and compares each returned match with the oldest one
// still owed. Stimulus starts with directed corner cases and then runs
// phases of random queries and palette writes under several palette sizes,
// with bursty input and a stalling output side.
// ----------------------------------------------------------------------------
module nearest_palette_colour_match_test;
  import npcm_pkg::*;

  // One input transaction, as it travels on tuser/tdata.
  typedef struct packed {
    logic       kind;
    logic [6:0] entry;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } colour_item_t;

  // One result transaction.
  typedef struct packed {
    logic [6:0]  index;
    logic [17:0] distance;
  } match_t;

  // Colours loaded into entries 0..126 at reset; entry 127 resets to black.
  localparam logic [23:0] BOOT_COLOURS [127] = '{
    24'h000000, 24'hf5f5f5, 24'h2a77a1, 24'h840410, 24'h263739, 24'h86446e, 24'hd78e10,
    24'h4c75b7, 24'hbdbec6, 24'h5e7072, 24'h46597a, 24'h656a79, 24'h5d7e8d, 24'h58595a,
    24'hd6dad6, 24'h9ca1a3, 24'h335f3f, 24'h730e1a, 24'h7b0a2a, 24'h9f9d94, 24'h3b4e78,
    24'h732e3e, 24'h691e3b, 24'h96918c, 24'h515459, 24'h3f3e45, 24'ha5a9a7, 24'h635c5a,
    24'h3d4a68, 24'h979592, 24'h421f21, 24'h5f272b, 24'h8494ab, 24'h767b7c, 24'h646464,
    24'h5a5752, 24'h252527, 24'h2d3a35, 24'h93a396, 24'h6d7a88, 24'h221918, 24'h6f675f,
    24'h7c1c2a, 24'h5f0a15, 24'h193826, 24'h5d1b20, 24'h9d9872, 24'h7a7560, 24'h989586,
    24'hadb0b0, 24'h848988, 24'h304f45, 24'h4d6268, 24'h162248, 24'h272f4b, 24'h7d6256,
    24'h9ea4ab, 24'h9c8d71, 24'h6d1822, 24'h4e6881, 24'h9c9c98, 24'h917347, 24'h661c26,
    24'h949d9f, 24'ha4a7a5, 24'h8e8c46, 24'h341a1e, 24'h6a7a8c, 24'haaad8e, 24'hab988f,
    24'h851f2e, 24'h6f8297, 24'h585853, 24'h9aa790, 24'h601a23, 24'h20202c, 24'ha4a096,
    24'haa9d84, 24'h78222b, 24'h0e316d, 24'h722a3f, 24'h7b715e, 24'h741d28, 24'h1e2e32,
    24'h4d322f, 24'h7c1b44, 24'h2e5b20, 24'h395a83, 24'h6d2837, 24'ha7a28f, 24'hafb1b1,
    24'h364155, 24'h6d6c6e, 24'h0f6a89, 24'h204b6b, 24'h2b3e57, 24'h9b9f9d, 24'h6c8495,
    24'h4d8495, 24'hae9b7f, 24'h406c8f, 24'h1f253b, 24'hab9276, 24'h134573, 24'h96816c,
    24'h64686a, 24'h105082, 24'ha19983, 24'h385694, 24'h525661, 24'h7f6956, 24'h8c929a,
    24'h596e87, 24'h473532, 24'h44624f, 24'h730a27, 24'h223457, 24'h640d1b, 24'ha3adc6,
    24'h695853, 24'h9b8b80, 24'h620b1c, 24'h5b5d5e, 24'h624428, 24'h731827, 24'h1b376d,
    24'hec6aae
  };

  // Cycles with no transaction on any port before the run is declared hung.
  localparam int STALL_LIMIT = 3000;
  // Quiet cycles after the last match, longer than one full-palette scan.
  localparam int TAIL_CYCLES = 200;
  // Settle time before a register write.
  localparam int CFG_SETTLE  = 8;

  // --------------------------------------------------------------------------
  // Scoreboard: private palette, palette size and the queue of owed matches.
  // --------------------------------------------------------------------------
  class palette_match_board;
    logic [23:0] palette [PAL_DEPTH];
    logic [7:0]  size_reg;
    match_t      owed_matches [$];
    int          errors;

    function void load_defaults();
      for (int i = 0; i < PAL_DEPTH; i++)
        palette[i] = (i < 127) ? BOOT_COLOURS[i] : 24'h000000;
      size_reg = 8'd127;
      errors   = 0;
    endfunction

    // Number of entries a query walks: zero acts as one, above depth clamps.
    function int span();
      if (size_reg == 0) return 1;
      if (size_reg > PAL_DEPTH) return PAL_DEPTH;
      return size_reg;
    endfunction

    function match_t nearest(colour_item_t q);
      longint best_d;
      longint d;
      int     best_i;
      int     dr;
      int     dg;
      int     db;
      match_t m;
      best_d = 64'hFFFFFFFF;
      best_i = 0;
      for (int i = 0; i < span(); i++) begin
        dr = int'(palette[i][23:16]) - int'(q.red);
        dg = int'(palette[i][15:8])  - int'(q.green);
        db = int'(palette[i][7:0])   - int'(q.blue);
        d  = dr * dr + dg * dg + db * db;
        // strict compare keeps the lowest index on a tie
        if (d < best_d) begin
          best_d = d;
          best_i = i;
        end
      end
      m.index    = 7'(best_i);
      m.distance = 18'(best_d);
      return m;
    endfunction

    function int pending();
      return owed_matches.size();
    endfunction

    task report(string what);
      errors++;
      if (errors <= 100)
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // Apply an accepted input transaction: write the entry or owe a match.
    task note_item(colour_item_t it);
      if (it.kind == KIND_WRITE) begin
        if (it.entry < PAL_DEPTH)
          palette[it.entry] = {it.red, it.green, it.blue};
      end else begin
        owed_matches.push_back(nearest(it));
      end
    endtask

    task check_match(match_t got);
      match_t want;
      if (owed_matches.size() == 0) begin
        report($sformatf("unexpected match index %0d distance %0d",
                         got.index, got.distance));
      end else begin
        want = owed_matches.pop_front();
        if (got.index !== want.index)
          report($sformatf("best_index %0d, expected %0d", got.index, want.index));
        if (got.distance !== want.distance)
          report($sformatf("best_distance %0d, expected %0d",
                           got.distance, want.distance));
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // DUT signals and instance
  // --------------------------------------------------------------------------
  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;
  logic        s_tvalid;
  logic        s_tready;
  logic        s_tuser;       // [0] kind
  logic [31:0] s_tdata;       // [6:0] entry_index, [14:7] red, [22:15] green,
                              // [30:23] blue, [31] zero
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;       // [6:0] best_index, [24:7] best_distance, [31:25] zero

  nearest_palette_colour_match uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tuser     (s_tuser),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

  palette_match_board board;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Monitor: sample every port at the rising edge. All bench-driven inputs
  // change through nonblocking assignments, so these are pre-edge values.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    colour_item_t seen;
    match_t       got;
    if (!rst) begin
      // register write lands at this edge
      if (cfg_wr_en)
        board.size_reg = cfg_wr_data;
      if (s_tvalid && s_tready) begin
        seen.kind  = s_tuser;
        seen.entry = s_tdata[6:0];
        seen.red   = s_tdata[14:7];
        seen.green = s_tdata[22:15];
        seen.blue  = s_tdata[30:23];
        board.note_item(seen);
      end
      if (m_tvalid && m_tready) begin
        got.index    = m_tdata[6:0];
        got.distance = m_tdata[24:7];
        board.check_match(got);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run when no transaction moves for too long.
  // --------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || cfg_wr_en || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[%0t] watchdog: no transaction for %0d cycles", $realtime, STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: ready follows a pattern whose style is redrawn at random when
  // the current style's run ends - always ready, coin toss per cycle, or long stalls.
  // --------------------------------------------------------------------------
  int rx_style     = 0;
  int rx_style_left = 0;
  int rx_hold      = 0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready      <= 1'b0;
      rx_style      <= 0;
      rx_style_left <= 0;
      rx_hold       <= 0;
    end else begin
      if (rx_style_left == 0) begin
        rx_style      <= $urandom_range(0, 2);
        rx_style_left <= $urandom_range(100, 400);
      end else begin
        rx_style_left <= rx_style_left - 1;
      end
      if (rx_hold > 0) begin
        rx_hold <= rx_hold - 1;
      end else begin
        case (rx_style)
          0: begin
            m_tready <= 1'b1;
          end
          1: begin
            m_tready <= $urandom_range(0, 1);
          end
          default: begin
            // alternate a long low stretch with a short high one
            m_tready <= ~m_tready;
            rx_hold  <= m_tready ? $urandom_range(5, 40) : $urandom_range(0, 8);
          end
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender tasks
  // --------------------------------------------------------------------------

  // Present one transaction and hold it until the edge that accepts it.
  task automatic push_item(colour_item_t it);
    s_tvalid <= 1'b1;
    s_tuser  <= it.kind;
    s_tdata  <= {1'b0, it.blue, it.green, it.red, it.entry};
    do @(posedge clk); while (!s_tready);
  endtask

  // Drop valid and hold off until every owed match has come back.
  task automatic drain_matches();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  // Write palette_size while the block is idle.
  task automatic set_palette_size(logic [7:0] value);
    drain_matches();
    repeat (CFG_SETTLE) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic colour_item_t query(logic [23:0] rgb);
    colour_item_t it;
    it.kind  = KIND_QUERY;
    it.entry = 7'($urandom_range(0, 127));
    {it.red, it.green, it.blue} = rgb;
    return it;
  endfunction

  function automatic colour_item_t entry_write(logic [6:0] entry, logic [23:0] rgb);
    colour_item_t it;
    it.kind  = KIND_WRITE;
    it.entry = entry;
    {it.red, it.green, it.blue} = rgb;
    return it;
  endfunction

  function automatic logic [7:0] nudge(logic [7:0] v);
    int t;
    t = int'(v) + $urandom_range(0, 12) - 6;
    if (t < 0) t = 0;
    if (t > 255) t = 255;
    return 8'(t);
  endfunction

  // Random transaction shaped around the current palette: writes mostly
  // land inside the searched span, queries are random, near an entry,
  // exactly on an entry, or at the corners of the colour cube.
  function automatic colour_item_t random_item();
    int          roll;
    int          pick;
    logic [6:0]  entry;
    logic [23:0] rgb;
    roll = $urandom_range(0, 99);
    pick = $urandom_range(0, board.span() - 1);
    if (roll < 25) begin
      if ($urandom_range(0, 4) != 0)
        entry = 7'($urandom_range(0, board.span() - 1));
      else
        entry = 7'($urandom_range(0, 127));
      // copy an existing colour now and then to create ties
      if ($urandom_range(0, 9) < 3)
        rgb = board.palette[pick];
      else
        rgb = 24'($urandom);
      return entry_write(entry, rgb);
    end
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      rgb = 24'($urandom);
    end else if (roll < 70) begin
      rgb = board.palette[pick];
      rgb = {nudge(rgb[23:16]), nudge(rgb[15:8]), nudge(rgb[7:0])};
    end else if (roll < 85) begin
      rgb = board.palette[pick];
    end else begin
      rgb = {{8{1'($urandom_range(0, 1))}}, {8{1'($urandom_range(0, 1))}},
             {8{1'($urandom_range(0, 1))}}};
    end
    return query(rgb);
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  // Palette sizes per random phase: edges, zero, over-depth, small values.
  int phase_sizes [14] = '{1, 0, 2, 128, 5, 255, 16, 129, 3, 8, 127, 12, -1, -1};

  initial begin
    int burst_left;
    int gap;
    bit steady;
    board = new();
    board.load_defaults();
    rst         <= 1'b1;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= 8'd0;
    s_tvalid    <= 1'b0;
    s_tuser     <= 1'b0;
    s_tdata     <= 32'd0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset palette, size 127.
    push_item(query(24'h000000));                 // exact black, entry 0
    push_item(query(24'hffffff));
    push_item(query(24'hec6aae));                 // last searched entry
    push_item(query(24'hf5f5f5));
    push_item(query(24'hff0000));
    push_item(query(24'h00ff00));
    push_item(query(24'h0000ff));
    push_item(entry_write(7'd127, 24'hffffff));   // outside the span at 127
    push_item(query(24'hffffff));
    push_item(entry_write(7'd126, 24'h2a77a1));   // duplicate of entry 2
    push_item(query(24'h2a77a1));                 // tie, lowest index wins
    push_item(entry_write(7'd85, 24'h55aa55));
    push_item(query(24'h55aa54));

    // Full depth: entry 127 now takes part.
    set_palette_size(8'd128);
    push_item(query(24'hffffff));
    push_item(query(24'h000000));                 // exact black, entry 0

    // Size zero searches entry 0 only; white gives the largest distance.
    set_palette_size(8'd0);
    push_item(query(24'hffffff));
    push_item(query(24'h000000));
    push_item(entry_write(7'd0, 24'h808080));
    push_item(query(24'h7f7f7f));

    // Size above depth clamps to the full palette.
    set_palette_size(8'd255);
    push_item(query(24'hffffff));
    push_item(query(24'h2a77a1));

    set_palette_size(8'd1);
    push_item(query(24'hff00ff));
    push_item(entry_write(7'd42, 24'h123456));
    push_item(query(24'h123456));                 // entry 42 not searched

    // Random phases, about 100 transactions each.
    for (int p = 0; p < 14; p++) begin
      if (phase_sizes[p] < 0)
        set_palette_size(8'($urandom_range(1, 40)));
      else
        set_palette_size(8'(phase_sizes[p]));
      // every third phase skips the random input gaps between bursts
      steady     = (p % 3 == 2);
      burst_left = $urandom_range(1, 16);
      for (int n = 0; n < 100; n++) begin
        push_item(random_item());
        if ($urandom_range(0, 99) < 3) begin
          // pause until the block has answered everything
          drain_matches();
        end else if (!steady) begin
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap        = $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
      end
    end

    drain_matches();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.pending() != 0)
      board.report($sformatf("%0d matches never arrived", board.pending()));
    if (board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
